// ===== rtl/sms_pkg.sv =====
package sms_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned DataWidth   = 2 * BitsPerByte;
  localparam int unsigned HoldWidth   = 7;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = HoldWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSpiMode       = 2'd0,
    CfgLsbFirst      = 2'd1,
    CfgHalfPeriod    = 2'd2,
    CfgHighByteFirst = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]           spi_mode;
    logic                 lsb_first;
    logic [HoldWidth-1:0] half_period;
    logic                 high_byte_first;
  } cfg_t;

  typedef struct packed {
    logic                 sck_level;
    logic                 mosi_level;
    logic                 busy_res;
    logic                 done_res;
    logic [DataWidth-1:0] rx_data;
  } res_t;

endpackage

// ===== rtl/sms_core.sv =====
module sms_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  sms_pkg::cfg_t                cfg_i,
  input  logic                         start_req_i,
  input  logic [sms_pkg::DataWidth-1:0] tx_data_i,
  input  logic                         two_bytes_i,
  input  logic                         miso_level_i,
  output sms_pkg::res_t                res_o
);
  import sms_pkg::*;

  localparam int unsigned PosWidth = $clog2(DataWidth);
  localparam int unsigned BitWidth = $clog2(BitsPerByte);

  logic                 busy_q, busy_d;
  logic                 wf_q, wf_d;
  logic [DataWidth-1:0] tx_q, tx_d;
  logic [DataWidth-1:0] rx_q, rx_d;
  logic [PosWidth-1:0]  bc_q, bc_d;
  logic [1:0]           ph_q, ph_d;
  logic [HoldWidth-1:0] hold_q, hold_d;
  logic                 clk_q, clk_d;
  logic                 mosi_q, mosi_d;
  logic                 cpol_q, cpol_d;
  logic                 cpha_q, cpha_d;
  logic                 lsb_q, lsb_d;
  logic                 hbf_q, hbf_d;

  logic                 sample;
  logic [PosWidth-1:0]  pos;
  logic [BitWidth-1:0]  bit_sel;
  logic [HoldWidth-1:0] hold_inc;
  logic [HoldWidth-1:0] hp_eff;
  logic [1:0]           ph_inc;
  logic [1:0]           steps;
  logic [PosWidth-1:0]  last_bit;
  logic                 done;
  logic                 busy_out;
  logic [DataWidth-1:0] rx_out;

  always_comb begin
    busy_d   = busy_q;
    wf_d     = wf_q;
    tx_d     = tx_q;
    rx_d     = rx_q;
    bc_d     = bc_q;
    ph_d     = ph_q;
    hold_d   = hold_q;
    clk_d    = clk_q;
    mosi_d   = mosi_q;
    cpol_d   = cpol_q;
    cpha_d   = cpha_q;
    lsb_d    = lsb_q;
    hbf_d    = hbf_q;
    sample   = 1'b0;
    pos      = '0;
    bit_sel  = '0;
    hold_inc = '0;
    ph_inc   = '0;
    done     = 1'b0;
    busy_out = 1'b0;
    rx_out   = '0;
    hp_eff   = (cfg_i.half_period == '0) ? HoldWidth'(1) : cfg_i.half_period;
    steps    = '0;
    last_bit = '0;

    if (!busy_q) begin
      clk_d = cfg_i.spi_mode[1];
      if (start_req_i) begin
        busy_d = 1'b1;
        wf_d   = two_bytes_i;
        tx_d   = two_bytes_i ? tx_data_i
                             : {{(DataWidth-BitsPerByte){1'b0}}, tx_data_i[BitsPerByte-1:0]};
        rx_d   = '0;
        bc_d   = '0;
        ph_d   = '0;
        hold_d = '0;
        cpol_d = cfg_i.spi_mode[1];
        cpha_d = cfg_i.spi_mode[0];
        lsb_d  = cfg_i.lsb_first;
        hbf_d  = cfg_i.high_byte_first;
      end
    end

    if (busy_d) begin
      busy_out = 1'b1;
      steps    = cpha_d ? 2'd3 : 2'd2;
      last_bit = wf_d ? PosWidth'(2 * BitsPerByte - 1) : PosWidth'(BitsPerByte - 1);
      bit_sel  = lsb_d ? bc_d[BitWidth-1:0]
                       : BitWidth'(BitsPerByte - 1) - bc_d[BitWidth-1:0];
      pos      = {wf_d & (bc_d[PosWidth-1] ^ hbf_d), bit_sel};

      if (hold_d == '0) begin
        if (cpha_d) begin
          if (ph_d == 2'd0) begin
            clk_d = ~cpol_d;
          end else if (ph_d == 2'd1) begin
            clk_d  = ~cpol_d;
            mosi_d = tx_d[pos];
          end else begin
            clk_d  = cpol_d;
            sample = 1'b1;
          end
        end else begin
          if (ph_d == 2'd0) begin
            clk_d  = cpol_d;
            mosi_d = tx_d[pos];
          end else begin
            clk_d  = ~cpol_d;
            sample = 1'b1;
          end
        end
        if (sample) begin
          rx_d[pos] = miso_level_i;
        end
      end

      hold_inc = hold_d + HoldWidth'(1);
      if (hold_inc >= hp_eff || hold_inc == '0) begin
        hold_d = '0;
        ph_inc = ph_d + 2'd1;
        if (ph_inc >= steps) begin
          ph_d = '0;
          if (bc_d >= last_bit) begin
            busy_d = 1'b0;
            done   = 1'b1;
            rx_out = rx_d;
          end else begin
            bc_d = bc_d + PosWidth'(1);
          end
        end else begin
          ph_d = ph_inc;
        end
      end else begin
        hold_d = hold_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      wf_q   <= 1'b0;
      tx_q   <= '0;
      rx_q   <= '0;
      bc_q   <= '0;
      ph_q   <= '0;
      hold_q <= '0;
      clk_q  <= 1'b0;
      mosi_q <= 1'b0;
      cpol_q <= 1'b0;
      cpha_q <= 1'b0;
      lsb_q  <= 1'b0;
      hbf_q  <= 1'b0;
    end else if (en_i) begin
      busy_q <= busy_d;
      wf_q   <= wf_d;
      tx_q   <= tx_d;
      rx_q   <= rx_d;
      bc_q   <= bc_d;
      ph_q   <= ph_d;
      hold_q <= hold_d;
      clk_q  <= clk_d;
      mosi_q <= mosi_d;
      cpol_q <= cpol_d;
      cpha_q <= cpha_d;
      lsb_q  <= lsb_d;
      hbf_q  <= hbf_d;
    end
  end

  assign res_o.sck_level  = clk_d;
  assign res_o.mosi_level = mosi_d;
  assign res_o.busy_res   = busy_out;
  assign res_o.done_res   = done;
  assign res_o.rx_data    = rx_out;

endmodule

// ===== rtl/spi_master_shifter.sv =====
// each accepted request's result is captured in the output register for the master side
// throughput: one request per cycle while s_axis_tready is high, each request one frame step
// the output register takes a new result whenever it is empty or being drained
// reset clears the frame state, the line levels and the output valid,
// and loads the configuration defaults (mode 0, msb first, half period 1)
module spi_master_shifter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sms_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [sms_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [23:0]                     s_axis_tdata,  // start_req, tx_data, miso_level
  input  logic                            s_axis_tuser,  // two_bytes
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [23:0]                     m_axis_tdata,  // sck_level, mosi_level, busy_res, rx_data
  output logic                            m_axis_tlast   // done_res
);
  import sms_pkg::*;

  cfg_t cfg_q;
  res_t res;
  res_t res_q;
  logic m_valid_q;
  logic accept;

  assign s_axis_tready = ~m_valid_q | m_axis_tready;
  assign accept        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spi_mode        <= '0;
      cfg_q.lsb_first       <= 1'b0;
      cfg_q.half_period     <= HoldWidth'(1);
      cfg_q.high_byte_first <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSpiMode:       cfg_q.spi_mode        <= cfg_data_i[1:0];
        CfgLsbFirst:      cfg_q.lsb_first       <= cfg_data_i[0];
        CfgHalfPeriod:    cfg_q.half_period     <= cfg_data_i[HoldWidth-1:0];
        CfgHighByteFirst: cfg_q.high_byte_first <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  sms_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (accept),
    .cfg_i        (cfg_q),
    .start_req_i  (s_axis_tdata[0]),
    .tx_data_i    (s_axis_tdata[DataWidth:1]),
    .two_bytes_i  (s_axis_tuser),
    .miso_level_i (s_axis_tdata[DataWidth+1]),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      m_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = res_q.done_res;
  assign m_axis_tdata  = {5'b0, res_q.rx_data, res_q.busy_res, res_q.mosi_level,
                          res_q.sck_level};

endmodule

// ===== verif/spi_master_shifter_test.sv =====
`timescale 1ns / 1ps

import sms_pkg::*;

class spi_shift_board;
  bit [1:0]  mode;
  bit        lsb;
  bit [6:0]  half;
  bit        hbf;

  bit        sck;
  bit        mosi;
  bit        busy;
  bit [3:0]  nbit;
  bit [1:0]  step;
  bit [6:0]  hold;
  bit [15:0] txs;
  bit [15:0] rxs;
  bit        word;
  bit        f_cpol;
  bit        f_cpha;
  bit        f_lsb;
  bit        f_hbf;

  res_t      line_levels_q[$];
  int        errors;
  int        shown;

  function new();
    half = 7'd1;
  endfunction

  function void write_reg(cfg_idx_e idx, bit [6:0] val);
    case (idx)
      CfgSpiMode:       mode = val[1:0];
      CfgLsbFirst:      lsb  = val[0];
      CfgHalfPeriod:    half = val;
      CfgHighByteFirst: hbf  = val[0];
      default: ;
    endcase
  endfunction

  function bit frame_busy();
    return busy;
  endfunction

  function int pending();
    return line_levels_q.size();
  endfunction

  // position of the current bit inside the 16-bit word
  function int unsigned bit_pos();
    int unsigned b;
    bit          hi;
    b  = nbit[2:0];
    hi = word ? (nbit[3] ? !f_hbf : f_hbf) : 1'b0;
    if (!f_lsb) begin
      b = BitsPerByte - 1 - b;
    end
    return (hi ? BitsPerByte : 0) + b;
  endfunction

  function void note_request(bit start, bit [15:0] txd, bit two, bit miso);
    int unsigned pos;
    int unsigned steps;
    int unsigned hp;
    int unsigned last;
    bit          take_bit;
    bit          done;
    res_t        r;
    done     = 1'b0;
    take_bit = 1'b0;
    r        = '0;
    if (!busy) begin
      sck = mode[1];
      if (start) begin
        busy   = 1'b1;
        word   = two;
        txs    = two ? txd : {8'h00, txd[7:0]};
        rxs    = '0;
        nbit   = '0;
        step   = '0;
        hold   = '0;
        f_cpol = mode[1];
        f_cpha = mode[0];
        f_lsb  = lsb;
        f_hbf  = hbf;
      end
    end
    if (busy) begin
      pos       = bit_pos();
      steps     = f_cpha ? 3 : 2;
      hp        = (half == 0) ? 1 : half;
      r.busy_res = 1'b1;
      if (hold == 0) begin
        if (f_cpha) begin
          if (step == 0) begin
            sck = !f_cpol;
          end else if (step == 1) begin
            sck  = !f_cpol;
            mosi = txs[pos];
          end else begin
            sck      = f_cpol;
            take_bit = 1'b1;
          end
        end else begin
          if (step == 0) begin
            sck  = f_cpol;
            mosi = txs[pos];
          end else begin
            sck      = !f_cpol;
            take_bit = 1'b1;
          end
        end
        if (take_bit) begin
          rxs[pos] = miso;
        end
      end
      hold = hold + 7'd1;
      if (hold >= hp || hold == 0) begin
        hold = '0;
        step = step + 2'd1;
        if (step >= steps) begin
          last = word ? 2 * BitsPerByte - 1 : BitsPerByte - 1;
          step = '0;
          if (nbit >= last) begin
            busy = 1'b0;
            done = 1'b1;
          end else begin
            nbit = nbit + 4'd1;
          end
        end
      end
    end
    r.sck_level  = sck;
    r.mosi_level = mosi;
    r.done_res   = done;
    r.rx_data    = done ? rxs : 16'h0000;
    line_levels_q.push_back(r);
  endfunction

  function void check_result(res_t got);
    res_t want;
    if (line_levels_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected result: sck %0b mosi %0b busy %0b done %0b rx %04h",
                 got.sck_level, got.mosi_level, got.busy_res, got.done_res, got.rx_data);
      end
      return;
    end
    want = line_levels_q.pop_front();
    if (got.sck_level !== want.sck_level || got.mosi_level !== want.mosi_level ||
        got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
        got.rx_data !== want.rx_data) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: expected sck %0b mosi %0b busy %0b done %0b rx %04h",
                 want.sck_level, want.mosi_level, want.busy_res, want.done_res,
                 want.rx_data);
        $display("          actual   sck %0b mosi %0b busy %0b done %0b rx %04h",
                 got.sck_level, got.mosi_level, got.busy_res, got.done_res, got.rx_data);
      end
    end
  endfunction
endclass

module spi_master_shifter_test;
  localparam int unsigned StuckLimit = 2000;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   cfg_we_i       = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i      = '0;
  logic [CfgWidth-1:0]    cfg_data_i     = '0;
  logic                   s_axis_tvalid  = 1'b0;
  logic                   s_axis_tready;
  logic [23:0]            s_axis_tdata   = '0;  // start_req, tx_data, miso_level
  logic                   s_axis_tuser   = 1'b0;  // two_bytes
  logic                   m_axis_tvalid;
  logic                   m_axis_tready  = 1'b0;
  logic [23:0]            m_axis_tdata;  // sck_level, mosi_level, busy_res, rx_data
  logic                   m_axis_tlast;  // done_res

  spi_shift_board sb = new();

  bit          calm_tx;
  bit          calm_rx;
  int unsigned stall_left;
  int unsigned stuck_cycles;

  spi_master_shifter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!calm_rx && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.sck_level  = m_axis_tdata[0];
      got.mosi_level = m_axis_tdata[1];
      got.busy_res   = m_axis_tdata[2];
      got.rx_data    = m_axis_tdata[18:3];
      got.done_res   = m_axis_tlast;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == StuckLimit) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic send_item(bit start, bit [15:0] txd, bit two, bit miso);
    int unsigned gap;
    if (!calm_tx && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b000000, miso, txd, start};
    s_axis_tuser  <= two;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(start, txd, two, miso);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_regs(bit [1:0] mode, bit lsb, bit [6:0] hp, bit hbf);
    cfg_idx_e    idx;
    bit [6:0]    val;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_idx_e'(i);
      case (idx)
        CfgSpiMode:       val = {5'b0, mode};
        CfgLsbFirst:      val = {6'b0, lsb};
        CfgHalfPeriod:    val = hp;
        CfgHighByteFirst: val = {6'b0, hbf};
        default:          val = '0;
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx;
      cfg_data_i <= val;
      @(posedge clk_i);
      sb.write_reg(idx, val);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(bit [1:0] mode, bit lsb, bit [6:0] hp, bit hbf,
                           int unsigned n, bit byte_only, bit calm);
    drain();
    calm_tx = calm;
    calm_rx = calm;
    set_regs(mode, lsb, hp, hbf);
    repeat (n) begin
      send_item($urandom_range(0, 3) != 0, 16'($urandom_range(0, 65535)),
                byte_only ? 1'b0 : 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int unsigned random_items;
    int unsigned n;
    bit [6:0]    hp;
    random_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // byte frame with all ones, starts while busy and on the done tick ignored
    calm_tx = 1'b1;
    calm_rx = 1'b1;
    set_regs(2'd0, 1'b0, 7'd1, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b0, 1'b1);
    for (int i = 1; i < 16; i++) begin
      send_item(1'b1, 16'h0000, 1'b1, 1'(i));
    end
    send_item(1'b1, 16'h0000, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) begin
      send_item(1'b0, 16'hFFFF, 1'b0, 1'b1);
    end
    // registers rewritten with a word frame in flight, zero half period
    drain();
    set_regs(2'd3, 1'b1, 7'd0, 1'b1);

    run_phase(2'd3, 1'b1, 7'd0, 1'b1, 120, 1'b0, 1'b0);
    run_phase(2'd1, 1'b0, 7'd127, 1'b0, 50, 1'b0, 1'b0);
    run_phase(2'd1, 1'b1, 7'd2, 1'b0, 150, 1'b0, 1'b1);

    // get idle, then start a slow byte frame at a half period of 64
    drain();
    set_regs(2'd0, 1'b0, 7'd1, 1'b0);
    while (sb.frame_busy()) begin
      send_item(1'b0, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    run_phase(2'd2, 1'b0, 7'd64, 1'b1, 260, 1'b1, 1'b0);

    while (random_items < 260) begin
      n  = $urandom_range(60, 160);
      hp = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(4, 16)) : 7'($urandom_range(1, 3));
      run_phase(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), hp,
                1'($urandom_range(0, 1)), n, 1'b0, $urandom_range(0, 3) == 0);
      random_items += n;
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
